[sv/oahi_pkg.sv]
// shared types and constants of the open-addressing hash insert block
// no dependencies; used by oahi_ctrl, oahi_dpath and the top level

package oahi_pkg;

	localparam int TABLE_SIZE_DEF = 32;
	localparam int KEY_W          = 31;
	localparam int SLOT_W         = 5;
	localparam int COEFF_W        = 10;
	localparam int CFG_IDX_W      = 1;
	// modulo unit sequencing: key, c1, c2, then a drain step
	localparam int CNT_W          = 2;

	localparam logic [COEFF_W-1:0] LINEAR_RST = COEFF_W'(1);
	localparam logic [COEFF_W-1:0] SQUARE_RST = COEFF_W'(0);

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_READ   = 2'd1,
		FN_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_READ     = 2'd2,
		ST_CLEARED  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINEAR = 1'd0,
		REG_SQUARE = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		func_t              func;
		logic [KEY_W-1:0]   key;
		logic [SLOT_W-1:0]  slot_index;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [KEY_W-1:0]   stored_key;
		logic               occupied;
	} result_t;

	typedef struct packed {
		logic    load;
		logic    mod_step;
		logic    probe_init;
		logic    probe_rd;
		logic    probe_adv;
		logic    ins_wr;
		logic    slot_rd;
		logic    sweep_clr;
		logic    sweep_wr;
		logic    emit;
		status_t emit_status;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic probe_last;
		logic slot_busy;
		logic sweep_last;
	} sts_t;

endpackage

[sv/oahi_ctrl.sv]
// controller state machine of the hash insert block
// depends on oahi_pkg; drives oahi_dpath through cmd_t and reads sts_t

module oahi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  oahi_pkg::func_t  func,
	input  oahi_pkg::sts_t   sts,
	output oahi_pkg::cmd_t   cmd,
	output logic             busy
);

	typedef enum logic [3:0] {
		S_INIT_CLR,
		S_IDLE,
		S_MOD,
		S_PROBE_INIT,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_SLOT_RD,
		S_SLOT_WAIT,
		S_CLR
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt       = state_q;
		cmd             = '0;
		cmd.emit_status = oahi_pkg::ST_INSERTED;
		unique case (state_q)
			S_INIT_CLR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					unique case (func)
						oahi_pkg::FN_INSERT: begin
							cmd.load  = 1'b1;
							state_nxt = S_MOD;
						end
						oahi_pkg::FN_READ: begin
							cmd.load  = 1'b1;
							state_nxt = S_SLOT_RD;
						end
						oahi_pkg::FN_CLEAR: begin
							cmd.sweep_clr = 1'b1;
							state_nxt     = S_CLR;
						end
						// undefined code: item dropped
						default: state_nxt = S_IDLE;
					endcase
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_nxt = S_PROBE_INIT;
				end
			end
			S_PROBE_INIT: begin
				cmd.probe_init = 1'b1;
				state_nxt      = S_PROBE_RD;
			end
			S_PROBE_RD: begin
				cmd.probe_rd = 1'b1;
				state_nxt    = S_PROBE_CHK;
			end
			S_PROBE_CHK: begin
				priority if (!sts.slot_busy) begin
					cmd.ins_wr      = 1'b1;
					cmd.emit        = 1'b1;
					cmd.emit_status = oahi_pkg::ST_INSERTED;
					state_nxt       = S_IDLE;
				end else if (sts.probe_last) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = oahi_pkg::ST_FULL;
					state_nxt       = S_IDLE;
				end else begin
					cmd.probe_adv = 1'b1;
					state_nxt     = S_PROBE_RD;
				end
			end
			S_SLOT_RD: begin
				cmd.slot_rd = 1'b1;
				state_nxt   = S_SLOT_WAIT;
			end
			S_SLOT_WAIT: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = oahi_pkg::ST_READ;
				state_nxt       = S_IDLE;
			end
			S_CLR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = oahi_pkg::ST_CLEARED;
					state_nxt       = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[sv/oahi_dpath.sv]
// datapath of the hash insert block: coefficients, modulo reduction, probe
// sequence, slot memory and result register; depends on oahi_pkg

module oahi_dpath #(
	parameter int TABLE_SIZE = oahi_pkg::TABLE_SIZE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  oahi_pkg::item_t                     item,
	input  logic                                wr_en,
	input  logic [oahi_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [oahi_pkg::COEFF_W-1:0]        wr_data,
	input  oahi_pkg::cmd_t                      cmd,
	output oahi_pkg::sts_t                      sts,
	output logic                                done,
	output oahi_pkg::result_t                   result
);

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int KEY_W   = oahi_pkg::KEY_W;
	localparam int COEFF_W = oahi_pkg::COEFF_W;
	localparam int CNT_W   = oahi_pkg::CNT_W;
	localparam int ENTRY_W = KEY_W + 1;
	localparam int RECIP_W = 32;
	localparam int PROD_W  = KEY_W + RECIP_W;
	localparam int RECIP_SHIFT = KEY_W + IDX_W;
	localparam logic [IDX_W:0]   SIZE_EXT = (IDX_W+1)'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [KEY_W-1:0] SIZE_KEY = KEY_W'(TABLE_SIZE);
	// ceil(2^RECIP_SHIFT / size): (x * RECIP) >> RECIP_SHIFT is x / size for any 31-bit x
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT)
		+ 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
	localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(3);

	// (a + b) mod size for a, b already below size
	function automatic logic [IDX_W-1:0] mod_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
		logic [IDX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= SIZE_EXT) begin
			sum = sum - SIZE_EXT;
		end
		return sum[IDX_W-1:0];
	endfunction

	logic [COEFF_W-1:0] lin_q;
	logic [COEFF_W-1:0] sq_q;

	oahi_pkg::item_t    item_q;
	logic [COEFF_W-1:0] lin_ld_q;
	logic [COEFF_W-1:0] sq_ld_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [KEY_W-1:0]   mod_op;
	logic [KEY_W-1:0]   op_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [KEY_W-1:0]   quot;
	logic [IDX_W-1:0]   mod_rem;
	logic [IDX_W-1:0]   home_q;
	logic [IDX_W-1:0]   lin_m_q;
	logic [IDX_W-1:0]   sq_m_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   delta_q;
	logic [IDX_W-1:0]   step_q;
	logic [IDX_W-1:0]   probe_q;
	logic [IDX_W-1:0]   sweep_q;

	logic [ENTRY_W-1:0] mem [TABLE_SIZE];
	logic [ENTRY_W-1:0] rdata_q;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_raddr;

	logic               in_range;
	logic [IDX_W-1:0]   slot_addr;
	oahi_pkg::result_t  res_nxt;
	oahi_pkg::result_t  res_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q <= oahi_pkg::LINEAR_RST;
			sq_q  <= oahi_pkg::SQUARE_RST;
		end else if (wr_en) begin
			if (wr_index == oahi_pkg::REG_LINEAR) begin
				lin_q <= wr_data;
			end else begin
				sq_q <= wr_data;
			end
		end
	end

	// operands of the modulo unit in turn: key, c1, c2
	always_comb begin
		unique case (cnt_q)
			CNT_W'(0): mod_op = item_q.key;
			CNT_W'(1): mod_op = KEY_W'(lin_ld_q);
			default:   mod_op = KEY_W'(sq_ld_q);
		endcase
	end

	assign quot    = KEY_W'(prod_s1 >> RECIP_SHIFT);
	assign mod_rem = IDX_W'(op_s1 - quot * SIZE_KEY);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= item;
			lin_ld_q <= lin_q;
			sq_ld_q  <= sq_q;
		end else if (cmd.mod_step) begin
			// one operand enters the multiplier, the one before it leaves reduced
			op_s1   <= mod_op;
			prod_s1 <= PROD_W'(mod_op) * PROD_W'(RECIP);
			unique case (cnt_q)
				CNT_W'(1): home_q  <= mod_rem;
				CNT_W'(2): lin_m_q <= mod_rem;
				CNT_W'(3): sq_m_q  <= mod_rem;
				default: ;
			endcase
		end
		// step between probes i and i+1 is c1 + c2*(2i+1), grown by 2*c2 each time
		if (cmd.probe_init) begin
			pos_q   <= home_q;
			delta_q <= mod_add(lin_m_q, sq_m_q);
			step_q  <= mod_add(sq_m_q, sq_m_q);
		end else if (cmd.probe_adv) begin
			pos_q   <= mod_add(pos_q, delta_q);
			delta_q <= mod_add(delta_q, step_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			probe_q <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.mod_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.probe_init) begin
				probe_q <= '0;
			end else if (cmd.probe_adv) begin
				probe_q <= probe_q + IDX_W'(1);
			end
			if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.sweep_wr) begin
				sweep_q <= sweep_q + IDX_W'(1);
			end
		end
	end

	assign in_range  = (int'(item_q.slot_index) < TABLE_SIZE);
	assign slot_addr = IDX_W'(item_q.slot_index);

	always_comb begin
		mem_we    = cmd.sweep_wr | cmd.ins_wr;
		mem_waddr = cmd.sweep_wr ? sweep_q : pos_q;
		mem_wdata = cmd.sweep_wr ? '0 : {1'b1, item_q.key};
		mem_re    = cmd.probe_rd | cmd.slot_rd;
		mem_raddr = cmd.probe_rd ? pos_q : slot_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_comb begin
		res_nxt        = '0;
		res_nxt.status = cmd.emit_status;
		unique case (cmd.emit_status)
			oahi_pkg::ST_INSERTED: begin
				res_nxt.slot       = oahi_pkg::SLOT_W'(pos_q);
				res_nxt.stored_key = item_q.key;
				res_nxt.occupied   = 1'b1;
			end
			oahi_pkg::ST_READ: begin
				res_nxt.slot     = item_q.slot_index;
				res_nxt.occupied = in_range & rdata_q[KEY_W];
				if (in_range && rdata_q[KEY_W]) begin
					res_nxt.stored_key = rdata_q[KEY_W-1:0];
				end
			end
			oahi_pkg::ST_FULL, oahi_pkg::ST_CLEARED: begin
				res_nxt.slot = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign sts.mod_done   = (cnt_q == MOD_LAST);
	assign sts.probe_last = (probe_q == LAST_IDX);
	assign sts.slot_busy  = rdata_q[KEY_W];
	assign sts.sweep_last = (sweep_q == LAST_IDX);

	assign done   = done_q;
	assign result = res_q;

endmodule

[sv/open_addressing_hash_insert.sv]
// Open-addressing hash table with quadratic probing, TABLE_SIZE slots of 31-bit keys.
// An item is taken when start is high and busy is low; its one result appears on result
// for a single cycle with done high and must be taken then, as the receiver cannot stall.
// An insert first reduces the key and both probe coefficients modulo TABLE_SIZE by
// reciprocal multiplication, one operand a cycle through a two-stage unit, then probes
// up to TABLE_SIZE slots of the slot memory (one read and one write port), each probe a
// read in S_PROBE_RD and a check in S_PROBE_CHK; done and the result are registered.
// A read passes S_SLOT_RD and S_SLOT_WAIT, a clear writes one slot per cycle, and an
// undefined operation code is dropped with no result. After reset the block stays busy
// while it empties the table. The coefficient registers are written through wr_en,
// wr_index and wr_data; the user must write them only while the block is idle, as the
// block does not enforce it. Depends on oahi_pkg, oahi_ctrl and oahi_dpath.

module open_addressing_hash_insert #(
	parameter int TABLE_SIZE = oahi_pkg::TABLE_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  oahi_pkg::item_t                 item,
	output logic                            done,
	output oahi_pkg::result_t               result,
	input  logic                            wr_en,
	input  logic [oahi_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [oahi_pkg::COEFF_W-1:0]    wr_data
);

	oahi_pkg::cmd_t cmd;
	oahi_pkg::sts_t sts;

	oahi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	oahi_dpath #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd      (cmd),
		.sts      (sts),
		.done     (done),
		.result   (result)
	);

endmodule
